// ===== src/rtpl_pkg.sv =====
// range table predecessor lookup: shared types, widths and codes
// used by range_table_predecessor_lookup; no dependencies

package rtpl_pkg;

   // default table size
   localparam int DEFAULT_TABLE_DEPTH = 65536;

   // fixed field widths
   localparam int INDEX_W = 16;
   localparam int START_W = 32;
   localparam int COUNT_W = 17;

   // packed input word layout
   localparam int REQ_DATA_W = 80;
   localparam int REQ_INDEX_LSB = 0;
   localparam int REQ_START_LSB = 16;
   localparam int REQ_ADDR_LSB = 48;

   // command codes carried in req_tuser
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } rtpl_state_type;

endpackage

// ===== src/rtpl_ram.sv =====
// range start table storage: one write port, one registered read port
// depends on nothing; instantiated by range_table_predecessor_lookup

module rtpl_ram #(
   parameter int DEPTH = 65536,
   parameter int AW = 16,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/range_table_predecessor_lookup.sv =====
// Range table predecessor lookup. A load word (req_tuser = 0) writes one 32-bit range start
// into the table at entry_index; loads at or beyond TABLE_DEPTH are dropped.
// A lookup word (req_tuser = 1) runs an upper-bound binary search over the first
// entries_in_use entries (clamped to TABLE_DEPTH) and returns the index of the last entry
// whose start is at or below the address, with found low when there is none. The table must
// be sorted ascending and every searched entry written before use; the table has no reset.
// A lookup passes through an accept step, a run of probes of the table RAM's registered read
// port, whose read data feeds the compare that picks the next probe address, and a finish
// step that loads the result register once it is empty or being read. The block takes no
// word while a lookup runs; a result waiting in the output register does not stop the next
// word from being accepted.
// depends on rtpl_pkg and rtpl_ram

module range_table_predecessor_lookup #(
   parameter int TABLE_DEPTH = rtpl_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration: entries_in_use
   input  logic                                csr_we,
   input  logic [rtpl_pkg::COUNT_W-1:0]        csr_wdata,
   // input words
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [15:0] entry_index, [47:16] range_start, [79:48] lookup_address
   input  logic [rtpl_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] command
   input  logic                                req_tuser,
   // result words
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [15:0] match_index
   output logic [rtpl_pkg::INDEX_W-1:0]        rsp_tdata,
   // [0] found
   output logic                                rsp_tuser
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int XW = (AW > rtpl_pkg::INDEX_W) ? AW : rtpl_pkg::INDEX_W;
   localparam int PW = (CW > rtpl_pkg::INDEX_W) ? CW : rtpl_pkg::INDEX_W;

   // configuration register
   logic [rtpl_pkg::COUNT_W-1:0] entries_ff;

   // sequencer and search registers
   rtpl_pkg::rtpl_state_type state_ff, state_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [rtpl_pkg::START_W-1:0] addr_ff;

   // result register
   logic                         rsp_valid_ff;
   logic [rtpl_pkg::INDEX_W-1:0] rsp_index_ff;
   logic                         rsp_found_ff;

   // input word fields
   logic [rtpl_pkg::INDEX_W-1:0] entry_index;
   logic [rtpl_pkg::START_W-1:0] range_start;
   logic [rtpl_pkg::START_W-1:0] lookup_address;
   logic [XW-1:0]                index_ext;

   logic accept, is_lookup, index_ok;
   logic [CW-1:0] n_used;

   // table ram port
   logic                         ram_we, ram_re;
   logic [AW-1:0]                ram_raddr;
   logic [rtpl_pkg::START_W-1:0] ram_rdata;

   // probe update
   logic          start_le;
   logic [CW-1:0] mid_plus1, mid_right, mid_left;
   logic          more_right, more_left, go_on;
   logic          out_free, rsp_load;
   logic [PW-1:0] pos_ext, pos_m1;

   assign entry_index = req_tdata[rtpl_pkg::REQ_INDEX_LSB +: rtpl_pkg::INDEX_W];
   assign range_start = req_tdata[rtpl_pkg::REQ_START_LSB +: rtpl_pkg::START_W];
   assign lookup_address = req_tdata[rtpl_pkg::REQ_ADDR_LSB +: rtpl_pkg::START_W];
   assign index_ext = XW'(entry_index);
   assign index_ok = 32'(entry_index) < 32'(TABLE_DEPTH);

   assign accept = req_tvalid && req_tready;
   assign is_lookup = (req_tuser == rtpl_pkg::CMD_LOOKUP);

   // entries in use, clamped to the table size
   assign n_used = (32'(entries_ff) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(entries_ff);

   // both candidate next probes are formed while the ram read is in flight
   assign mid_plus1 = mid_ff + CW'(1);
   assign mid_right = mid_plus1 + ((hi_ff - mid_plus1) >> 1);
   assign mid_left = lo_ff + ((mid_ff - lo_ff) >> 1);
   assign more_right = mid_plus1 < hi_ff;
   assign more_left = lo_ff < mid_ff;

   // compare the probed start and pick the half to keep
   assign start_le = ram_rdata <= addr_ff;
   assign lo_in = start_le ? mid_plus1 : lo_ff;
   assign hi_in = start_le ? hi_ff : mid_ff;
   assign mid_in = start_le ? mid_right : mid_left;
   assign go_on = start_le ? more_right : more_left;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rtpl_pkg::ST_IDLE: begin
            if (accept && is_lookup) begin
               state_in = (n_used == '0) ? rtpl_pkg::ST_FINISH : rtpl_pkg::ST_SEARCH;
            end
         end
         rtpl_pkg::ST_SEARCH: begin
            if (!go_on) begin
               state_in = rtpl_pkg::ST_FINISH;
            end
         end
         rtpl_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = rtpl_pkg::ST_IDLE;
            end
         end
         default: state_in = rtpl_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      ram_we = 1'b0;
      ram_re = 1'b0;
      ram_raddr = mid_in[AW-1:0];
      rsp_load = 1'b0;
      case (state_ff)
         rtpl_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            ram_we = accept && !is_lookup && index_ok;
            ram_re = accept && is_lookup && (n_used != '0);
            ram_raddr = AW'(n_used >> 1);
         end
         rtpl_pkg::ST_SEARCH: begin
            ram_re = go_on;
         end
         rtpl_pkg::ST_FINISH: begin
            rsp_load = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // table storage
   rtpl_ram #(
      .DEPTH(TABLE_DEPTH),
      .AW(AW),
      .DW(rtpl_pkg::START_W)
   ) u_table (
      .clock(clock),
      .wr_en(ram_we),
      .wr_addr(index_ext[AW-1:0]),
      .wr_data(range_start),
      .rd_en(ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtpl_pkg::ST_IDLE;
         entries_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            entries_ff <= csr_wdata;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // search bounds
   always_ff @(posedge clock) begin
      if (state_ff == rtpl_pkg::ST_IDLE && accept && is_lookup) begin
         lo_ff <= '0;
         hi_ff <= n_used;
         mid_ff <= n_used >> 1;
         addr_ff <= lookup_address;
      end else if (state_ff == rtpl_pkg::ST_SEARCH) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         mid_ff <= mid_in;
      end
   end

   // result: the entry just before the upper bound
   assign pos_ext = PW'(lo_ff);
   assign pos_m1 = pos_ext - PW'(1);

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_found_ff <= (lo_ff != '0);
         rsp_index_ff <= (lo_ff != '0) ? pos_m1[rtpl_pkg::INDEX_W-1:0] : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_index_ff;
   assign rsp_tuser = rsp_found_ff;

   // search window never empties while probing
   a_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == rtpl_pkg::ST_SEARCH |-> lo_ff < hi_ff)
      else $error("search window empty while probing");

   // probe stays inside the window
   a_probe: assert property (@(posedge clock) disable iff (reset)
      state_ff == rtpl_pkg::ST_SEARCH |-> (mid_ff >= lo_ff) && (mid_ff < hi_ff))
      else $error("probe outside search window");

   // a lookup always holds the block busy for the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      accept && is_lookup |=> !req_tready)
      else $error("lookup did not occupy the sequencer");

   // a new result only comes from the finish step
   a_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == rtpl_pkg::ST_FINISH)
      else $error("result raised outside finish step");

endmodule
